/* rtl/mcg_pkg.sv */
// Shared types and codes for the monotonic clock guard.
// Depends on nothing; monotonic_clock_guard, mcg_stats and the testbench import it.
package mcg_pkg;

	// Request types
	localparam logic [1:0] RT_TIME  = 2'd0;
	localparam logic [1:0] RT_STAT  = 2'd1;
	localparam logic [1:0] RT_CLEAR = 2'd2;

	// Classification codes
	localparam logic [2:0] CL_OK        = 3'd0;
	localparam logic [2:0] CL_LAG       = 3'd1;
	localparam logic [2:0] CL_LOCAL     = 3'd2;
	localparam logic [2:0] CL_EXHAUSTED = 3'd3;
	localparam logic [2:0] CL_INVALID   = 3'd4;
	localparam logic [2:0] CL_NO_CLOCK  = 3'd5;

	// Statistic indexes
	localparam int ST_COUNT = 11;
	localparam logic [3:0] ST_READS           = 4'd0;
	localparam logic [3:0] ST_NO_CLOCK        = 4'd1;
	localparam logic [3:0] ST_UNKNOWN         = 4'd2;
	localparam logic [3:0] ST_MAX_RETRIES     = 4'd3;
	localparam logic [3:0] ST_INVALID         = 4'd4;
	localparam logic [3:0] ST_LAG_COUNT       = 4'd5;
	localparam logic [3:0] ST_MAX_LAG         = 4'd6;
	localparam logic [3:0] ST_REGRESSIONS     = 4'd7;
	localparam logic [3:0] ST_EXHAUSTIONS     = 4'd8;
	localparam logic [3:0] ST_MAX_BACKWARD    = 4'd9;
	localparam logic [3:0] ST_API_REGRESSIONS = 4'd10;

	// Configuration register indexes (paddr[2])
	localparam logic CFG_CLOCK_READY = 1'b0;
	localparam logic CFG_RETRY_LIMIT = 1'b1;

	localparam logic [15:0] RETRY_LIMIT_RST = 16'd4;

	// Statistic update issued by the classify stage, one per transfer
	typedef struct packed {
		logic        clear;
		logic        reads;
		logic        no_clock;
		logic        unknown;
		logic        retry_en;
		logic [15:0] retries;
		logic        invalid;
		logic        lag;
		logic [63:0] lag_delta;
		logic        regress;
		logic        exhaust;
		logic [63:0] back_delta;
	} stat_upd_t;

endpackage

/* rtl/monotonic_clock_guard.sv */
// Top level of the monotonic clock guard: APB registers, two-stage pipeline
// around the per-CPU sample RAM, classification and output register.
// Depends on mcg_pkg, mcg_last_ram and mcg_stats.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  req     | req_valid / req_ready  | req_type cpu_id cpu_known raw_valid
//          |                        | raw_ns retry_count stat_select
//  rsp     | rsp_valid / rsp_ready  | time_ns classification step_ns hard_fail
//          |                        | stat_value
//  apb     | psel penable pready    | pwrite paddr pwdata prdata
//
// One request per cycle sustained while results are taken; a request's result passes the
// classify stage (RAM read) and then the output register before it transfers.
// A write-back to the slot read by the next request is forwarded around the RAM.
// Reset clears seen bits, global time, statistics and registers; a RAM word is
// read only once its seen bit is set, so the RAM needs no clearing pass.
// A stalled result holds the output register; the classify stage keeps one
// more request and then req_ready drops.
module monotonic_clock_guard #(
	parameter int CPU_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request channel
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  req_type,
	input  logic [3:0]  cpu_id,
	input  logic        cpu_known,
	input  logic        raw_valid,
	input  logic [63:0] raw_ns,
	input  logic [15:0] retry_count,
	input  logic [3:0]  stat_select,
	// result channel
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [63:0] time_ns,
	output logic [2:0]  classification,
	output logic [63:0] step_ns,
	output logic        hard_fail,
	output logic [63:0] stat_value
);
	import mcg_pkg::*;

	localparam int DEPTH = CPU_SLOTS + 1;
	localparam int IDX_W = $clog2(DEPTH);

	// Configuration registers
	logic        clock_ready_q;
	logic [15:0] retry_limit_q;

	// Classify stage
	logic             s1_valid_q;
	logic [1:0]       type_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             unknown_s1;
	logic             svalid_s1;
	logic [63:0]      sample_s1;
	logic [15:0]      retries_s1;
	logic [3:0]       sel_s1;
	logic             fwd_s1;
	logic [63:0]      fwd_data_s1;

	// State outside the RAM
	logic [DEPTH-1:0] seen_q;
	logic [63:0]      glob_q;

	// Output register
	logic        rsp_valid_q;
	logic [63:0] time_q;
	logic [2:0]  cls_q;
	logic [63:0] delta_q;
	logic        hard_q;
	logic [63:0] stat_q;

	logic             accept;
	logic             adv;
	logic             in_unknown;
	logic [IDX_W-1:0] in_idx;
	logic [63:0]      ram_rd;
	logic [63:0]      last_raw;
	logic             seen;
	logic             is_time;
	logic             live;
	logic             regress;
	logic             exhaust;
	logic             lag;
	logic             upd_local;
	logic             upd_global;
	logic [63:0]      back_delta;
	logic [63:0]      lag_delta;
	logic [63:0]      time_c;
	logic [2:0]       cls_c;
	logic [63:0]      delta_c;
	logic             hard_c;
	logic [63:0]      stat_rd;
	logic [63:0]      stat_c;
	stat_upd_t        upd;

	// APB port: always ready, write on access phase
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_ready_q <= 1'b0;
			retry_limit_q <= RETRY_LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				CFG_CLOCK_READY: clock_ready_q <= pwdata[0];
				CFG_RETRY_LIMIT: retry_limit_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			CFG_CLOCK_READY: prdata = {31'd0, clock_ready_q};
			CFG_RETRY_LIMIT: prdata = {16'd0, retry_limit_q};
			default:         prdata = 32'd0;
		endcase
	end

	// Handshake: classify stage moves when the output register is free
	assign adv       = s1_valid_q && (!rsp_valid_q || rsp_ready);
	assign req_ready = !s1_valid_q || adv;
	assign accept    = req_valid && req_ready;

	// Map unknown CPUs to the spare slot
	assign in_unknown = !cpu_known || (int'(cpu_id) >= CPU_SLOTS);
	assign in_idx     = in_unknown ? IDX_W'(CPU_SLOTS) : IDX_W'(cpu_id);

	// Load the classify stage; note a write-back to the slot being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept || (s1_valid_q && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1     <= req_type;
			idx_s1      <= in_idx;
			unknown_s1  <= in_unknown;
			svalid_s1   <= raw_valid;
			sample_s1   <= raw_ns;
			retries_s1  <= retry_count;
			sel_s1      <= stat_select;
			fwd_s1      <= adv && upd_local && (idx_s1 == in_idx);
			fwd_data_s1 <= sample_s1;
		end
	end

	mcg_last_ram #(
		.DEPTH (DEPTH),
		.AW    (IDX_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (in_idx),
		.rd_data (ram_rd),
		.wr_en   (adv && upd_local),
		.wr_addr (idx_s1),
		.wr_data (sample_s1)
	);

	// Classify the sample against the slot and global history
	assign last_raw   = fwd_s1 ? fwd_data_s1 : ram_rd;
	assign seen       = seen_q[idx_s1];
	assign is_time    = (type_s1 == RT_TIME);
	assign live       = is_time && clock_ready_q;
	assign regress    = svalid_s1 && seen && (sample_s1 < last_raw);
	assign exhaust    = regress && (retries_s1 >= retry_limit_q);
	assign lag        = svalid_s1 && !regress && (sample_s1 < glob_q);
	assign upd_local  = live && svalid_s1 && !regress;
	assign upd_global = live && svalid_s1;
	assign back_delta = last_raw - sample_s1;
	assign lag_delta  = glob_q - sample_s1;

	always_comb begin
		time_c  = 64'd0;
		cls_c   = CL_OK;
		delta_c = 64'd0;
		hard_c  = 1'b0;
		stat_c  = 64'd0;
		case (type_s1)
			RT_TIME: begin
				if (!clock_ready_q) begin
					cls_c = CL_NO_CLOCK;
				end else if (!svalid_s1) begin
					time_c = glob_q;
					cls_c  = CL_INVALID;
					hard_c = 1'b1;
				end else begin
					time_c = (sample_s1 >= glob_q) ? sample_s1 : glob_q;
					if (regress) begin
						cls_c   = exhaust ? CL_EXHAUSTED : CL_LOCAL;
						delta_c = back_delta;
						hard_c  = 1'b1;
					end else if (lag) begin
						cls_c   = CL_LAG;
						delta_c = lag_delta;
					end
				end
			end
			RT_STAT: stat_c = stat_rd;
			default: ;
		endcase
	end

	// Statistic update for this transfer
	always_comb begin
		upd            = '0;
		upd.clear      = adv && (type_s1 == RT_CLEAR);
		upd.reads      = adv && is_time;
		upd.no_clock   = adv && is_time && !clock_ready_q;
		upd.unknown    = adv && live && unknown_s1;
		upd.retry_en   = adv && live;
		upd.retries    = retries_s1;
		upd.invalid    = adv && live && !svalid_s1;
		upd.lag        = adv && live && lag;
		upd.lag_delta  = lag_delta;
		upd.regress    = adv && live && regress;
		upd.exhaust    = adv && live && exhaust;
		upd.back_delta = back_delta;
	end

	mcg_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.sel    (sel_s1),
		.value  (stat_rd)
	);

	// Commit seen bit and global time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			glob_q <= 64'd0;
		end else if (adv) begin
			if (upd_local) begin
				seen_q[idx_s1] <= 1'b1;
			end
			if (upd_global) begin
				glob_q <= time_c;
			end
		end
	end

	// Output register: hold until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			time_q  <= time_c;
			cls_q   <= cls_c;
			delta_q <= delta_c;
			hard_q  <= hard_c;
			stat_q  <= stat_c;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign time_ns        = time_q;
	assign classification = cls_q;
	assign step_ns        = delta_q;
	assign hard_fail      = hard_q;
	assign stat_value     = stat_q;

`ifndef SYNTH
	a_glob_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> glob_q >= $past(glob_q))
		else $error("global time stepped backward");

	a_hard_matches_class: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> hard_fail == ((classification == CL_INVALID) ||
			(classification == CL_LOCAL) || (classification == CL_EXHAUSTED)))
		else $error("hard_fail disagrees with classification");

	a_ok_no_delta: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (classification == CL_OK) |-> step_ns == 64'd0)
		else $error("ok result carries a delta");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> s1_valid_q && rsp_valid_q && !rsp_ready)
		else $error("request stalled without a blocked result");

	a_glob_follows_time: assert property (@(posedge clk) disable iff (!arst_n)
		adv && upd_global |=> glob_q == $past(time_c))
		else $error("global time not taken from returned time");
`endif

endmodule

/* rtl/mcg_last_ram.sv */
// Per-CPU last raw sample store: one write port, one registered read port.
// Depends on nothing; read returns the old word on a same-edge write.
module mcg_last_ram #(
	parameter int DEPTH = 17,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [63:0]   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [63:0]   wr_data
);

	logic [63:0] mem [DEPTH];

	// Write the updated sample
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Register the read word
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/mcg_stats.sv */
// Statistic counters and maxima, updated once per transfer and read by index.
// Depends on mcg_pkg for the update struct and statistic indexes.
module mcg_stats (
	input  logic              clk,
	input  logic              arst_n,
	input  mcg_pkg::stat_upd_t upd,
	input  logic [3:0]        sel,
	output logic [63:0]       value
);
	import mcg_pkg::*;

	logic [63:0] cnt_q [ST_COUNT];

	// Advance counters, raise maxima, or clear all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ST_COUNT; i++) begin
				cnt_q[i] <= 64'd0;
			end
		end else if (upd.clear) begin
			for (int i = 0; i < ST_COUNT; i++) begin
				cnt_q[i] <= 64'd0;
			end
		end else begin
			if (upd.reads) begin
				cnt_q[ST_READS] <= cnt_q[ST_READS] + 64'd1;
			end
			if (upd.no_clock) begin
				cnt_q[ST_NO_CLOCK] <= cnt_q[ST_NO_CLOCK] + 64'd1;
			end
			if (upd.unknown) begin
				cnt_q[ST_UNKNOWN] <= cnt_q[ST_UNKNOWN] + 64'd1;
			end
			if (upd.retry_en && ({48'd0, upd.retries} > cnt_q[ST_MAX_RETRIES])) begin
				cnt_q[ST_MAX_RETRIES] <= {48'd0, upd.retries};
			end
			if (upd.invalid) begin
				cnt_q[ST_INVALID] <= cnt_q[ST_INVALID] + 64'd1;
			end
			if (upd.lag) begin
				cnt_q[ST_LAG_COUNT] <= cnt_q[ST_LAG_COUNT] + 64'd1;
				if (upd.lag_delta > cnt_q[ST_MAX_LAG]) begin
					cnt_q[ST_MAX_LAG] <= upd.lag_delta;
				end
			end
			if (upd.regress) begin
				cnt_q[ST_REGRESSIONS] <= cnt_q[ST_REGRESSIONS] + 64'd1;
				if (upd.back_delta > cnt_q[ST_MAX_BACKWARD]) begin
					cnt_q[ST_MAX_BACKWARD] <= upd.back_delta;
				end
			end
			if (upd.exhaust) begin
				cnt_q[ST_EXHAUSTIONS] <= cnt_q[ST_EXHAUSTIONS] + 64'd1;
			end
		end
	end

	// Select a statistic; codes past the last read as zero
	always_comb begin
		if (sel < 4'(ST_COUNT)) begin
			value = cnt_q[sel];
		end else begin
			value = 64'd0;
		end
	end

endmodule

/* tb/tb_monotonic_clock_guard.sv */
// Self-checking testbench for monotonic_clock_guard: directed and random time reads,
// statistic reads and clears, checked against a predictor kept in a scoreboard class.
// Depends on mcg_pkg and the monotonic_clock_guard RTL.
`timescale 1ns / 1ps

module tb_monotonic_clock_guard;
	import mcg_pkg::*;

	localparam int CPU_SLOTS = 16;
	localparam int SPARE_SLOT = CPU_SLOTS;
	localparam logic [1:0] RT_UNUSED = 2'd3;
	localparam logic [3:0] ST_NONE = 4'd15;
	localparam int DRAIN_CYCLES = 4;
	localparam int DRAIN_LIMIT = 2000;

	typedef struct {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic        known;
		logic        valid;
		logic [63:0] sample;
		logic [15:0] retries;
		logic [3:0]  sel;
	} guard_req_t;

	typedef struct {
		logic [63:0] mono;
		logic [2:0]  cls;
		logic [63:0] delta;
		logic        hard;
		logic [63:0] stat;
	} guard_reply_t;

	// Predicted guard state and the replies still owed by the block
	class clock_guard_scoreboard;
		bit           clock_on;
		logic [15:0]  retry_lim;
		logic [63:0]  last_raw [CPU_SLOTS+1];
		bit           seen [CPU_SLOTS+1];
		logic [63:0]  global_ns;
		logic [63:0]  stats [ST_COUNT];
		guard_reply_t expected_replies [$];
		int           errors;
		int           checked;

		function new();
			clock_on = 1'b0;
			retry_lim = RETRY_LIMIT_RST;
			foreach (seen[i]) begin
				seen[i] = 1'b0;
				last_raw[i] = '0;
			end
			global_ns = '0;
			foreach (stats[i]) stats[i] = '0;
			errors = 0;
			checked = 0;
		endfunction

		function void write_reg(logic idx, logic [31:0] v);
			if (idx == CFG_CLOCK_READY)
				clock_on = v[0];
			else
				retry_lim = v[15:0];
		endfunction

		function logic [31:0] reg_value(logic idx);
			return (idx == CFG_CLOCK_READY) ? {31'b0, clock_on} : {16'b0, retry_lim};
		endfunction

		function void bump_max(logic [3:0] idx, logic [63:0] v);
			if (v > stats[idx])
				stats[idx] = v;
		endfunction

		// Work out the reply to one request and advance the guard state
		function guard_reply_t predict_reply(guard_req_t r);
			guard_reply_t o;
			int           idx;
			logic [63:0]  glob;
			bit           upd_local;
			bit           upd_global;
			o = '{mono: '0, cls: CL_OK, delta: '0, hard: 1'b0, stat: '0};
			upd_local = 1'b0;
			upd_global = 1'b0;
			case (r.kind)
				RT_TIME: begin
					stats[ST_READS] = stats[ST_READS] + 1;
					if (!clock_on) begin
						stats[ST_NO_CLOCK] = stats[ST_NO_CLOCK] + 1;
						o.cls = CL_NO_CLOCK;
					end else begin
						glob = global_ns;
						if (r.known && r.slot < CPU_SLOTS) begin
							idx = r.slot;
						end else begin
							idx = SPARE_SLOT;
							stats[ST_UNKNOWN] = stats[ST_UNKNOWN] + 1;
						end
						bump_max(ST_MAX_RETRIES, {48'b0, r.retries});
						o.mono = glob;
						if (!r.valid) begin
							o.cls = CL_INVALID;
							o.hard = 1'b1;
							stats[ST_INVALID] = stats[ST_INVALID] + 1;
						end else begin
							o.mono = (r.sample >= glob) ? r.sample : glob;
							upd_global = 1'b1;
							if (seen[idx] && r.sample < last_raw[idx]) begin
								o.cls = (r.retries >= retry_lim) ? CL_EXHAUSTED : CL_LOCAL;
								o.delta = last_raw[idx] - r.sample;
								o.hard = 1'b1;
								stats[ST_REGRESSIONS] = stats[ST_REGRESSIONS] + 1;
								if (o.cls == CL_EXHAUSTED)
									stats[ST_EXHAUSTIONS] = stats[ST_EXHAUSTIONS] + 1;
								bump_max(ST_MAX_BACKWARD, o.delta);
							end else begin
								upd_local = 1'b1;
								if (r.sample < glob) begin
									o.cls = CL_LAG;
									o.delta = glob - r.sample;
									stats[ST_LAG_COUNT] = stats[ST_LAG_COUNT] + 1;
									bump_max(ST_MAX_LAG, o.delta);
								end
							end
						end
						if (o.mono < glob) begin
							stats[ST_API_REGRESSIONS] = stats[ST_API_REGRESSIONS] + 1;
							o.mono = glob;
						end
						if (upd_local) begin
							last_raw[idx] = r.sample;
							seen[idx] = 1'b1;
						end
						if (upd_global)
							global_ns = o.mono;
					end
				end
				RT_STAT: begin
					if (r.sel < ST_COUNT)
						o.stat = stats[r.sel];
				end
				RT_CLEAR: begin
					foreach (stats[i]) stats[i] = '0;
				end
				default: ;
			endcase
			return o;
		endfunction

		function void note_request(guard_req_t r);
			expected_replies.push_back(predict_reply(r));
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_field(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report_mismatch($sformatf("reply %0d %s got %h expected %h",
					checked, name, got, want));
		endtask

		// Compare one transferred reply with the oldest prediction
		task check_reply(guard_reply_t got);
			guard_reply_t want;
			if (expected_replies.size() == 0) begin
				report_mismatch("reply with no request outstanding");
			end else begin
				want = expected_replies.pop_front();
				check_field("time_ns", got.mono, want.mono);
				check_field("classification", {61'b0, got.cls}, {61'b0, want.cls});
				check_field("step_ns", got.delta, want.delta);
				check_field("hard_fail", {63'b0, got.hard}, {63'b0, want.hard});
				check_field("stat_value", got.stat, want.stat);
			end
			checked++;
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid;
	logic        req_ready;
	logic [1:0]  req_type;
	logic [3:0]  cpu_id;
	logic        cpu_known;
	logic        raw_valid;
	logic [63:0] raw_ns;
	logic [15:0] retry_count;
	logic [3:0]  stat_select;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [63:0] time_ns;
	logic [2:0]  classification;
	logic [63:0] step_ns;
	logic        hard_fail;
	logic [63:0] stat_value;

	clock_guard_scoreboard sb;
	bit          calm;
	bit          hold_go;
	bit          holding;
	logic [63:0] now_ns;
	int unsigned skew [CPU_SLOTS];
	int          sent;
	int          settings_run;

	monotonic_clock_guard #(.CPU_SLOTS(CPU_SLOTS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
		.cpu_id(cpu_id), .cpu_known(cpu_known), .raw_valid(raw_valid),
		.raw_ns(raw_ns), .retry_count(retry_count), .stat_select(stat_select),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .time_ns(time_ns),
		.classification(classification), .step_ns(step_ns),
		.hard_fail(hard_fail), .stat_value(stat_value)
	);

	always #5 clk = ~clk;

	// Drop rsp_ready at random, hold it low during the hold-off, never in calm stretches
	always @(posedge clk) begin
		rsp_ready <= holding ? 1'b0 : (calm || $urandom_range(0, 99) >= 23);
	end

	// Sample each reply transfer on the falling edge before the edge that takes it
	always @(negedge clk) begin : reply_monitor
		guard_reply_t got;
		if (arst_n && rsp_valid && rsp_ready) begin
			got.mono = time_ns;
			got.cls = classification;
			got.delta = step_ns;
			got.hard = hard_fail;
			got.stat = stat_value;
			sb.check_reply(got);
		end
	end

	// Hold off the reply side for a long stretch so the request side backs up
	initial begin
		wait (hold_go);
		@(posedge clk);
		holding <= 1'b1;
		repeat (300) @(posedge clk);
		holding <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("tb_monotonic_clock_guard NOT OK");
		$finish;
	end

	function automatic guard_req_t mk_other(logic [1:0] kind, logic [3:0] sel);
		guard_req_t r;
		r.kind = kind;
		r.slot = 4'($urandom);
		r.known = 1'($urandom);
		r.valid = 1'($urandom);
		r.sample = {$urandom, $urandom};
		r.retries = 16'($urandom);
		r.sel = sel;
		return r;
	endfunction

	function automatic guard_req_t mk_time(logic [3:0] slot, logic known, logic valid,
			logic [63:0] sample, logic [15:0] retries);
		guard_req_t r;
		r = mk_other(RT_TIME, 4'($urandom));
		r.slot = slot;
		r.known = known;
		r.valid = valid;
		r.sample = sample;
		r.retries = retries;
		return r;
	endfunction

	// Mostly plausible CPU reads around a shared clock with per-CPU skew
	function automatic guard_req_t next_request();
		guard_req_t r;
		int         pick;
		int         slot;
		int         near_lim;
		r = mk_other(RT_STAT, 4'($urandom_range(0, 15)));
		pick = $urandom_range(0, 99);
		now_ns = now_ns + $urandom_range(0, 300);
		if (pick < 70) begin
			slot = $urandom_range(0, CPU_SLOTS - 1);
			r.kind = RT_TIME;
			r.slot = 4'(slot);
			r.known = ($urandom_range(0, 19) != 0);
			r.valid = ($urandom_range(0, 19) != 0);
			r.sample = now_ns + skew[slot];
			if ($urandom_range(0, 6) == 0)
				r.sample = r.sample - $urandom_range(1, 3000);
			case ($urandom_range(0, 9))
				8: begin
					near_lim = int'(sb.retry_lim) + $urandom_range(0, 2) - 1;
					if (near_lim < 0) near_lim = 0;
					if (near_lim > 65535) near_lim = 65535;
					r.retries = 16'(near_lim);
				end
				9: r.retries = 16'($urandom_range(0, 65535));
				default: r.retries = 16'($urandom_range(0, 6));
			endcase
		end else if (pick < 82) begin
			r.kind = RT_STAT;
		end else if (pick < 85) begin
			r.kind = RT_CLEAR;
		end else if (pick < 88) begin
			r.kind = RT_UNUSED;
		end else begin
			// noise: odd slots, big forward jumps, junk invalid samples
			r.kind = RT_TIME;
			if (r.valid) begin
				now_ns = now_ns + $urandom;
				r.sample = now_ns;
			end
		end
		return r;
	endfunction

	// Offer one request and hold it until the block takes it
	task automatic offer_request(guard_req_t r);
		req_valid <= 1'b1;
		req_type <= r.kind;
		cpu_id <= r.slot;
		cpu_known <= r.known;
		raw_valid <= r.valid;
		raw_ns <= r.sample;
		retry_count <= r.retries;
		stat_select <= r.sel;
		@(negedge clk);
		while (!req_ready) @(negedge clk);
		sb.note_request(r);
		sent++;
		@(posedge clk);
	endtask

	// Wait for every owed reply, then let the pipeline settle
	task automatic wait_idle();
		for (int w = 0; w < DRAIN_LIMIT && sb.expected_replies.size() != 0; w++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic idx, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		sb.write_reg(idx, v);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_check(logic idx);
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		got = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== sb.reg_value(idx))
			sb.report_mismatch($sformatf("register %0d read %h expected %h",
				idx, got, sb.reg_value(idx)));
		@(posedge clk);
	endtask

	task automatic set_register(logic idx, logic [31:0] v);
		apb_write(idx, v);
		apb_check(idx);
	endtask

	// Random traffic with gaps; optional calm stretch and hold-off trigger
	task automatic run_traffic(int n, int calm_n, int hold_at);
		bit quiet;
		for (int i = 0; i < n; i++) begin
			quiet = (i < calm_n);
			if (i == 0 && calm_n > 0)
				calm <= 1'b1;
			else if (i == calm_n && calm_n > 0)
				calm <= 1'b0;
			if (i == hold_at)
				hold_go <= 1'b1;
			while (!quiet && $urandom_range(0, 99) < 23) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
			offer_request(next_request());
		end
		req_valid <= 1'b0;
		calm <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(bit ready, int lim, int n, int calm_n, int hold_at);
		wait_idle();
		set_register(CFG_CLOCK_READY, ($urandom & ~32'h1) | {31'b0, ready});
		set_register(CFG_RETRY_LIMIT, ($urandom & 32'hFFFF_0000) | 32'(lim & 16'hFFFF));
		settings_run++;
		foreach (skew[i]) skew[i] = $urandom_range(0, 1000);
		run_traffic(n, calm_n, hold_at);
	endtask

	initial begin
		sb = new();
		sent = 0;
		settings_run = 1;
		now_ns = {24'b0, 8'($urandom), $urandom};
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_valid <= 1'b0;
		req_type <= RT_TIME;
		cpu_id <= '0;
		cpu_known <= 1'b0;
		raw_valid <= 1'b0;
		raw_ns <= '0;
		retry_count <= '0;
		stat_select <= '0;
		rsp_ready <= 1'b0;
		calm <= 1'b0;
		hold_go <= 1'b0;
		holding <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, then reads while the time source is down
		apb_check(CFG_CLOCK_READY);
		apb_check(CFG_RETRY_LIMIT);
		offer_request(mk_time(4'd0, 1'b1, 1'b1, 64'd100, 16'd0));
		offer_request(mk_time(4'd7, 1'b0, 1'b0, 64'd5, 16'd2));
		offer_request(mk_other(RT_STAT, ST_NO_CLOCK));
		req_valid <= 1'b0;
		@(posedge clk);
		wait_idle();
		set_register(CFG_CLOCK_READY, 32'h1);

		// ok, cross-CPU lag, local regression, retry exhausted, invalid, spare entry
		offer_request(mk_time(4'd0, 1'b1, 1'b1, 64'd1000, 16'd0));
		offer_request(mk_time(4'd1, 1'b1, 1'b1, 64'd900, 16'd0));
		offer_request(mk_time(4'd0, 1'b1, 1'b1, 64'd500, 16'd0));
		offer_request(mk_time(4'd0, 1'b1, 1'b1, 64'd400, 16'd4));
		offer_request(mk_time(4'd0, 1'b1, 1'b1, 64'd400, 16'd3));
		offer_request(mk_time(4'd2, 1'b1, 1'b0, {$urandom, $urandom}, 16'd7));
		offer_request(mk_time(4'd9, 1'b0, 1'b1, 64'd2000, 16'hFFFF));
		offer_request(mk_time(4'd3, 1'b0, 1'b1, 64'd1500, 16'd0));
		offer_request(mk_time(4'd4, 1'b1, 1'b1, 64'd1000, 16'd0));
		offer_request(mk_time(4'd15, 1'b1, 1'b1, 64'd3000, 16'd1));
		offer_request(mk_other(RT_STAT, ST_READS));
		offer_request(mk_other(RT_STAT, ST_MAX_RETRIES));
		offer_request(mk_other(RT_STAT, ST_MAX_BACKWARD));
		offer_request(mk_other(RT_STAT, ST_NONE));
		offer_request(mk_other(RT_CLEAR, ST_READS));
		offer_request(mk_other(RT_STAT, ST_READS));
		offer_request(mk_other(RT_UNUSED, 4'($urandom)));
		req_valid <= 1'b0;
		@(posedge clk);

		// several register settings, the extremes of retry_limit among them
		run_phase(1'b1, 4, 260, 0, -1);
		run_phase(1'b1, 1, 240, 0, -1);
		run_phase(1'b1, 65535, 260, 200, -1);
		run_phase(1'b0, $urandom_range(1, 65535), 80, 0, -1);
		run_phase(1'b1, 0, 260, 0, -1);
		run_phase(1'b1, $urandom_range(2, 16), 300, 0, 40);

		// extreme samples last, since they pin the global time at the top
		offer_request(mk_time(4'd5, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0));
		offer_request(mk_time(4'd6, 1'b1, 1'b1, 64'd0, 16'd0));
		offer_request(mk_time(4'd5, 1'b1, 1'b1, 64'd0, 16'hFFFF));
		offer_request(mk_other(RT_STAT, ST_MAX_LAG));
		offer_request(mk_other(RT_STAT, ST_MAX_BACKWARD));
		offer_request(mk_other(RT_STAT, ST_LAG_COUNT));
		req_valid <= 1'b0;
		@(posedge clk);
		wait_idle();

		if (sb.expected_replies.size() != 0)
			sb.report_mismatch($sformatf("%0d replies never arrived",
				sb.expected_replies.size()));
		$display("Covered %0d requests over %0d register settings; %0d replies compared.",
			sent, settings_run, sb.checked);
		$display("Mismatches: %0d", sb.errors);
		if (sb.errors == 0)
			$display("tb_monotonic_clock_guard OK");
		else
			$display("tb_monotonic_clock_guard NOT OK");
		$finish;
	end

endmodule
